// File: hw/rtl/assert_macros.svh
// assertion macros shared by the curve map rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in every cycle outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/plcm_pkg.sv
// shared types and constants of the piecewise linear curve map unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package plcm_pkg;

   // fixed field widths
   localparam int DATA_W  = 16;
   localparam int IDX_W   = 4;
   localparam int COUNT_W = 5;

   // curve table depth default
   localparam int MAX_POINTS_DEFAULT = 16;

   // register port
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 1'd0;

   // action field codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_MAP  = 1'b1;

   // command kinds handed from front to back
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] CMD_DROP = 2'd1;
   localparam logic [KIND_W-1:0] CMD_MAP  = 2'd2;

   // command queue, depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // iterative divider: one quotient bit a cycle
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] a;      // point x for loads, sample for maps
      logic signed [DATA_W-1:0] b;      // point y for loads
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hw/rtl/plcm_front.sv
// front end: accepts command transfers and classifies them for the back end
// depends on plcm_pkg
`timescale 1ns / 1ps

module plcm_front
   import plcm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_sample,
   input  qstat_type                qstat,
   output logic                     push,
   output cmd_type                  push_cmd
);

   logic slot_ok;

   assign busy    = qstat.full;
   assign push    = start && !qstat.full;
   assign slot_ok = 32'(req_point_index) < MAX_POINTS;

   always_comb begin
      push_cmd.index = req_point_index;
      push_cmd.b     = req_point_y;
      if (req_action == ACTION_MAP) begin
         push_cmd.kind = CMD_MAP;
         push_cmd.a    = req_sample;
      end else begin
         // loads to slots past the table are dropped
         push_cmd.kind = slot_ok ? CMD_LOAD : CMD_DROP;
         push_cmd.a    = req_point_x;
      end
   end

endmodule

// File: hw/rtl/plcm_queue.sv
// short command queue between front and back end
// depends on plcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcm_queue
   import plcm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type qstat
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign qstat.empty = fill_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !qstat.full, "push into full queue")
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= QCNT_W'(QUEUE_DEPTH), "fill overrun")

endmodule

// File: hw/rtl/plcm_back.sv
// back end: curve table memory, segment search, multiply and iterative divide
// depends on plcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcm_back
   import plcm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] point_count,
   input  qstat_type          qstat,
   input  cmd_type            head,
   output logic               pop,
   output logic               rsp_strobe,
   output logic [DATA_W-1:0]  rsp_drive_value
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LAST  = 3'd1;
   localparam logic [2:0] S_FIRST = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ABS   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   // table memory, x in the upper half, y in the lower
   logic [2*DATA_W-1:0] curve_ff [MAX_POINTS];
   logic [2*DATA_W-1:0] rd_entry_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              scan_idx_ff, scan_idx_in;
   logic signed [DATA_W-1:0]   sample_ff, sample_in;
   logic signed [DATA_W-1:0]   prev_x_ff, prev_x_in;
   logic signed [DATA_W-1:0]   prev_y_ff, prev_y_in;
   logic signed [DATA_W-1:0]   y0_ff, y0_in;
   logic signed [DATA_W-1:0]   y1_ff, y1_in;
   logic signed [DATA_W:0]     dx_ff, dx_in;
   logic signed [DATA_W:0]     dy_ff, dy_in;
   logic signed [DATA_W:0]     ds_ff, ds_in;
   logic signed [2*DATA_W+1:0] prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic [DIV_STEPS-1:0]       num_ff, num_in;
   logic [DATA_W-1:0]          den_ff, den_in;
   logic [DATA_W-1:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                       rsp_strobe_ff;
   logic [DATA_W-1:0]          rsp_value_ff;

   logic                       res_valid;
   logic [DATA_W-1:0]          res_value;
   logic [CW-1:0]              n_eff;
   logic [AW-1:0]              last_addr;
   logic signed [DATA_W-1:0]   rd_x, rd_y;
   logic signed [2*DATA_W+1:0] prod_mag;
   logic signed [DATA_W:0]     den_full;
   logic [DATA_W:0]            shifted;
   logic                       ge;
   logic signed [DIV_STEPS+1:0] fin_sum;

   assign rd_x = $signed(rd_entry_ff[2*DATA_W-1:DATA_W]);
   assign rd_y = $signed(rd_entry_ff[DATA_W-1:0]);

   always_comb begin
      if (32'(point_count) > MAX_POINTS) begin
         n_eff = CW'(MAX_POINTS);
      end else begin
         n_eff = CW'(point_count);
      end
   end

   assign last_addr = AW'(n_eff - CW'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         curve_ff[AW'(head.index)] <= {head.a, head.b};
      end
      rd_entry_ff <= curve_ff[rd_addr];
   end

   // helpers for the divider setup and step
   assign prod_mag = prod_ff[2*DATA_W+1] ? -prod_ff : prod_ff;
   assign den_full = dx_ff[DATA_W] ? -dx_ff : dx_ff;
   assign shifted  = {rem_ff, num_ff[DIV_STEPS-1]};
   assign ge       = shifted >= {1'b0, den_ff};

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      sample_in   = sample_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      ds_in       = ds_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      rd_addr     = '0;
      res_valid   = 1'b0;
      res_value   = sample_ff;
      fin_sum     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               unique case (head.kind)
                  CMD_LOAD: begin
                     wr_en = 1'b1;
                  end
                  CMD_MAP: begin
                     sample_in = head.a;
                     if (n_eff == '0) begin
                        res_valid = 1'b1;
                        res_value = head.a;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_FIRST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FIRST: begin
            // below the first x wins over above the last x
            if (sample_ff < rd_x) begin
               res_valid = 1'b1;
               res_value = rd_y;
               state_in  = S_IDLE;
            end else begin
               prev_x_in = rd_x;
               prev_y_in = rd_y;
               rd_addr   = last_addr;
               state_in  = S_LAST;
            end
         end
         S_LAST: begin
            if (sample_ff > rd_x) begin
               res_valid = 1'b1;
               res_value = rd_y;
               state_in  = S_IDLE;
            end else if (sample_ff <= prev_x_ff) begin
               // sample on the first x
               res_valid = 1'b1;
               res_value = prev_y_ff;
               state_in  = S_IDLE;
            end else begin
               rd_addr     = AW'(1);
               scan_idx_in = AW'(1);
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sample_ff <= rd_x) begin
               dx_in    = (DATA_W+1)'(rd_x) - (DATA_W+1)'(prev_x_ff);
               dy_in    = (DATA_W+1)'(rd_y) - (DATA_W+1)'(prev_y_ff);
               ds_in    = (DATA_W+1)'(sample_ff) - (DATA_W+1)'(prev_x_ff);
               y0_in    = prev_y_ff;
               y1_in    = rd_y;
               state_in = S_MUL;
            end else begin
               prev_x_in   = rd_x;
               prev_y_in   = rd_y;
               rd_addr     = scan_idx_ff + 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            if (dx_ff == '0) begin
               res_valid = 1'b1;
               res_value = y1_ff;
               state_in  = S_IDLE;
            end else begin
               prod_in  = ds_ff * dy_ff;
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            num_in     = prod_mag[DIV_STEPS-1:0];
            den_in     = den_full[DATA_W-1:0];
            rem_in     = '0;
            neg_in     = prod_ff[2*DATA_W+1] ^ dx_ff[DATA_W];
            bit_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in     = ge ? DATA_W'(shifted - {1'b0, den_ff}) : shifted[DATA_W-1:0];
            num_in     = {num_ff[DIV_STEPS-2:0], ge};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (neg_ff) begin
               fin_sum = (DIV_STEPS+2)'(y0_ff) - (DIV_STEPS+2)'(num_ff);
            end else begin
               fin_sum = (DIV_STEPS+2)'(y0_ff) + (DIV_STEPS+2)'(num_ff);
            end
            if (fin_sum > (DIV_STEPS+2)'(32767)) begin
               res_value = 16'h7FFF;
            end else if (fin_sum < -(DIV_STEPS+2)'(32768)) begin
               res_value = 16'h8000;
            end else begin
               res_value = fin_sum[DATA_W-1:0];
            end
            res_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      sample_ff    <= sample_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      ds_ff        <= ds_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_value_ff <= res_value;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_drive_value = rsp_value_ff;

   `ASSERT_IMPLIES(a_pop_idle, clock, reset, pop, state_ff == S_IDLE, "pop outside idle")
   `ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == S_SCAN, CW'(scan_idx_ff) < n_eff, "scan ran past last point")
   `ASSERT_NEXT(a_div_flow, clock, reset, state_ff == S_DIV, state_ff == S_DIV || state_ff == S_FIN, "divider left early")

endmodule

// File: hw/rtl/piecewise_linear_curve_map_unit.sv
// top level of the piecewise linear curve map unit; depends on plcm_pkg, front, queue and back
// a map resolves with no points, below the first x, above the last x or on the first x,
//    on a zero-width segment, or by interpolation through the multiply and the divider
// loads one per cycle while the back end is idle; a map holds the back end, while a
//    two-entry command queue takes further start transfers before busy is raised
// synchronous reset clears point_count, the queue and the control; table is undefined
`timescale 1ns / 1ps

module piecewise_linear_curve_map_unit
   import plcm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_sample,
   // result channel, one cycle strobe, no back-pressure
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_drive_value,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [PADDR_W-1:0]       paddr,
   input  logic [PDATA_W-1:0]       pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   logic [COUNT_W-1:0]   point_count_ff, point_count_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;
   logic                 push;
   logic                 pop;
   cmd_type              push_cmd;
   cmd_type              head;
   qstat_type            qstat;
   logic [DATA_W-1:0]    drive_raw;

   // register port: word index from the byte address, no wait states
   assign pready  = 1'b1;
   assign csr_idx = paddr[PADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      point_count_in = point_count_ff;
      if (csr_wr && csr_idx == REG_POINT_COUNT) begin
         point_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   // reads of addresses past the register list return zero
   assign prdata = (csr_idx == REG_POINT_COUNT) ? PDATA_W'(point_count_ff) : '0;

   // front end: takes the transfer and tags it load, drop or map
   plcm_front #(
      .MAX_POINTS(MAX_POINTS)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_point_index(req_point_index),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_sample     (req_sample),
      .qstat          (qstat),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // decoupling queue between the two halves
   plcm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .qstat   (qstat)
   );

   // back end: table memory, serial segment search, multiply, divide, saturate
   plcm_back #(
      .MAX_POINTS(MAX_POINTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .point_count    (point_count_ff),
      .qstat          (qstat),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_drive_value(drive_raw)
   );

   assign rsp_drive_value = $signed(drive_raw);

endmodule
